// ----- hdl/stt_pkg.sv -----
// Shared types, codes and character helpers for the source text tokenizer.
package stt_pkg;

    localparam int FIFO_DEPTH = 4;

    // token kinds
    localparam logic [3:0] K_PAYLOAD = 4'd0;
    localparam logic [3:0] K_IDENT   = 4'd1;
    localparam logic [3:0] K_INT     = 4'd2;
    localparam logic [3:0] K_SPACE   = 4'd3;
    localparam logic [3:0] K_CHAR    = 4'd4;
    localparam logic [3:0] K_STRING  = 4'd5;
    localparam logic [3:0] K_COMMENT = 4'd6;
    localparam logic [3:0] K_EOL     = 4'd7;
    localparam logic [3:0] K_EOF     = 4'd8;
    localparam logic [3:0] K_OTHER   = 4'd9;
    localparam logic [3:0] K_ERROR   = 4'd10;

    // characters
    localparam logic [7:0] CH_NUL    = 8'h00;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_NL     = 8'h0A;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_DQUOTE = 8'h22;
    localparam logic [7:0] CH_QUOTE  = 8'h27;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_UNDER  = 8'h5F;
    localparam logic [7:0] CH_LC_E   = 8'h65;
    localparam logic [7:0] CH_LC_N   = 8'h6E;
    localparam logic [7:0] CH_LC_T   = 8'h74;
    localparam logic [7:0] CH_X      = 8'h78;
    localparam logic [7:0] CH_ESC    = 8'h1B;

    typedef enum logic [11:0] {
        M_IDLE       = 12'b0000_0000_0001,
        M_IDENT      = 12'b0000_0000_0010,
        M_INT_ZERO   = 12'b0000_0000_0100,
        M_INT_DEC    = 12'b0000_0000_1000,
        M_INT_HEX    = 12'b0000_0001_0000,
        M_SPACE      = 12'b0000_0010_0000,
        M_CHAR_OPEN  = 12'b0000_0100_0000,
        M_CHAR_ESC   = 12'b0000_1000_0000,
        M_CHAR_CLOSE = 12'b0001_0000_0000,
        M_STR_BODY   = 12'b0010_0000_0000,
        M_STR_ESC    = 12'b0100_0000_0000,
        M_COMMENT    = 12'b1000_0000_0000
    } t_mode;

    typedef struct packed {
        logic [31:0] line;
        logic [31:0] col;
        logic [15:0] len;
    } t_pos;

    typedef struct packed {
        logic [3:0]  kind;
        logic [31:0] start_line;
        logic [31:0] start_column;
        logic [15:0] length;
        logic [63:0] int_value;
        logic [7:0]  byte_value;
        logic        last;
    } t_result;

    function automatic logic is_digit(input logic [7:0] c);
        return (c >= 8'h30) && (c <= 8'h39);
    endfunction

    function automatic logic is_ident_start(input logic [7:0] c);
        return ((c >= 8'h61) && (c <= 8'h7A)) || ((c >= 8'h41) && (c <= 8'h5A))
               || (c == CH_UNDER);
    endfunction

    function automatic logic is_ident_letter(input logic [7:0] c);
        return is_ident_start(c) || is_digit(c);
    endfunction

    function automatic logic breaks_literal(input logic [7:0] c);
        return (c == CH_NL) || (c == CH_NUL) || (c == CH_TAB);
    endfunction

    // {valid, nibble}
    function automatic logic [4:0] hex_digit(input logic [7:0] c);
        logic [4:0] r;
        r = 5'd0;
        if (is_digit(c))
            r = {1'b1, c[3:0]};
        else if (((c >= 8'h61) && (c <= 8'h66)) || ((c >= 8'h41) && (c <= 8'h46)))
            r = {1'b1, c[3:0] + 4'd9};  // 'a'/'A' end in 1, value 10
        return r;
    endfunction

    // {valid, decoded byte}
    function automatic logic [8:0] escape_value(input logic [7:0] c);
        logic [8:0] r;
        case (c)
            CH_LC_N:   r = {1'b1, CH_NL};
            CH_LC_T:   r = {1'b1, CH_TAB};
            CH_ZERO:   r = {1'b1, CH_NUL};
            CH_LC_E:   r = {1'b1, CH_ESC};
            CH_BSLASH: r = {1'b1, CH_BSLASH};
            CH_QUOTE:  r = {1'b1, CH_QUOTE};
            CH_DQUOTE: r = {1'b1, CH_DQUOTE};
            default:   r = 9'd0;
        endcase
        return r;
    endfunction

    // one byte taken into the current token; all counters saturate
    function automatic t_pos consume(input t_pos p, input logic [7:0] c);
        t_pos r;
        r = p;
        if (p.len != '1) r.len = p.len + 16'd1;
        if (c == CH_NL) begin
            if (p.line != '1) r.line = p.line + 32'd1;
            r.col = 32'd1;
        end else if (p.col != '1) begin
            r.col = p.col + 32'd1;
        end
        return r;
    endfunction

    function automatic t_result make_rec(input logic [3:0] kind, input logic [31:0] sl,
                                         input logic [31:0] sc, input logic [15:0] len,
                                         input logic [63:0] ival, input logic [7:0] bval);
        t_result r;
        r.kind         = kind;
        r.start_line   = sl;
        r.start_column = sc;
        r.length       = len;
        r.int_value    = ival;
        r.byte_value   = bval;
        r.last         = 1'b0;
        return r;
    endfunction

endpackage

// ----- hdl/stt_scan.sv -----
// Scanner state and per-byte next-state logic; yields up to two results per byte.
module stt_scan (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_accept,
    input  logic [7:0]        i_char_byte,
    output stt_pkg::t_result  o_res0,
    output stt_pkg::t_result  o_res1,
    output logic [1:0]        o_count
);
    import stt_pkg::*;

    t_mode       r_mode, n_mode;
    t_pos        r_pos, n_pos;
    logic [31:0] r_sl, n_sl;
    logic [31:0] r_sc, n_sc;
    logic [63:0] r_acc, n_acc;
    logic [7:0]  r_lit, n_lit;

    t_result     res [2];
    logic [1:0]  cnt;
    logic        redo;
    logic [4:0]  hx;
    logic [8:0]  es;
    logic [7:0]  c;

    assign c = i_char_byte;

    always_comb begin
        n_mode = r_mode;
        n_pos  = r_pos;
        n_sl   = r_sl;
        n_sc   = r_sc;
        n_acc  = r_acc;
        n_lit  = r_lit;
        res[0] = '0;
        res[1] = '0;
        cnt    = 2'd0;
        redo   = 1'b0;
        hx     = hex_digit(c);
        es     = escape_value(c);

        case (r_mode)
            M_IDENT: begin
                if (is_ident_letter(c)) begin
                    n_pos = consume(n_pos, c);
                end else begin
                    res[cnt[0]] = make_rec(K_IDENT, n_sl, n_sc, n_pos.len, 64'd0, 8'd0);
                    cnt = cnt + 2'd1;
                    redo = 1'b1;
                end
            end
            M_INT_ZERO: begin
                if (c == CH_X) begin
                    n_pos  = consume(n_pos, c);
                    n_mode = M_INT_HEX;
                end else begin
                    res[cnt[0]] = make_rec(K_INT, n_sl, n_sc, n_pos.len, n_acc, 8'd0);
                    cnt = cnt + 2'd1;
                    redo = 1'b1;
                end
            end
            M_INT_DEC: begin
                if (is_digit(c)) begin
                    // times ten as two shifts and an add
                    n_acc = (n_acc << 3) + (n_acc << 1) + {60'd0, c[3:0]};
                    n_pos = consume(n_pos, c);
                end else begin
                    res[cnt[0]] = make_rec(K_INT, n_sl, n_sc, n_pos.len, n_acc, 8'd0);
                    cnt = cnt + 2'd1;
                    redo = 1'b1;
                end
            end
            M_INT_HEX: begin
                if (hx[4]) begin
                    n_acc = {n_acc[59:0], hx[3:0]};
                    n_pos = consume(n_pos, c);
                end else if (c == CH_UNDER) begin
                    n_pos = consume(n_pos, c);
                end else begin
                    res[cnt[0]] = make_rec(K_INT, n_sl, n_sc, n_pos.len, n_acc, 8'd0);
                    cnt = cnt + 2'd1;
                    redo = 1'b1;
                end
            end
            M_SPACE: begin
                if (c == CH_SPACE) begin
                    n_pos = consume(n_pos, c);
                end else begin
                    res[cnt[0]] = make_rec(K_SPACE, n_sl, n_sc, n_pos.len, 64'd0, 8'd0);
                    cnt = cnt + 2'd1;
                    redo = 1'b1;
                end
            end
            M_CHAR_OPEN: begin
                if (breaks_literal(c)) begin
                    res[cnt[0]] = make_rec(K_ERROR, n_sl, n_sc, n_pos.len, 64'd0, 8'd0);
                    cnt = cnt + 2'd1;
                    redo = 1'b1;
                end else begin
                    n_pos = consume(n_pos, c);
                    if (c == CH_QUOTE) begin
                        res[cnt[0]] = make_rec(K_ERROR, n_sl, n_sc, n_pos.len, 64'd0, 8'd0);
                        cnt = cnt + 2'd1;
                        n_mode = M_IDLE;
                    end else if (c == CH_BSLASH) begin
                        n_mode = M_CHAR_ESC;
                    end else begin
                        n_lit  = c;
                        n_mode = M_CHAR_CLOSE;
                    end
                end
            end
            M_CHAR_ESC: begin
                if (breaks_literal(c)) begin
                    res[cnt[0]] = make_rec(K_ERROR, n_sl, n_sc, n_pos.len, 64'd0, 8'd0);
                    cnt = cnt + 2'd1;
                    redo = 1'b1;
                end else begin
                    n_pos = consume(n_pos, c);
                    if (!es[8]) begin
                        res[cnt[0]] = make_rec(K_ERROR, n_sl, n_sc, n_pos.len, 64'd0, 8'd0);
                        cnt = cnt + 2'd1;
                        n_mode = M_IDLE;
                    end else begin
                        n_lit  = es[7:0];
                        n_mode = M_CHAR_CLOSE;
                    end
                end
            end
            M_CHAR_CLOSE: begin
                if (c != CH_QUOTE) begin
                    res[cnt[0]] = make_rec(K_ERROR, n_sl, n_sc, n_pos.len, 64'd0, 8'd0);
                    cnt = cnt + 2'd1;
                    redo = 1'b1;
                end else begin
                    n_pos = consume(n_pos, c);
                    res[cnt[0]] = make_rec(K_CHAR, n_sl, n_sc, n_pos.len, 64'd0, n_lit);
                    cnt = cnt + 2'd1;
                    n_mode = M_IDLE;
                end
            end
            M_STR_BODY: begin
                if (breaks_literal(c)) begin
                    res[cnt[0]] = make_rec(K_ERROR, n_sl, n_sc, n_pos.len, 64'd0, 8'd0);
                    cnt = cnt + 2'd1;
                    redo = 1'b1;
                end else begin
                    n_pos = consume(n_pos, c);
                    if (c == CH_DQUOTE) begin
                        res[cnt[0]] = make_rec(K_STRING, n_sl, n_sc, n_pos.len, 64'd0, 8'd0);
                        cnt = cnt + 2'd1;
                        n_mode = M_IDLE;
                    end else if (c == CH_BSLASH) begin
                        n_mode = M_STR_ESC;
                    end else begin
                        res[cnt[0]] = make_rec(K_PAYLOAD, n_sl, n_sc, n_pos.len, 64'd0, c);
                        cnt = cnt + 2'd1;
                    end
                end
            end
            M_STR_ESC: begin
                if (breaks_literal(c)) begin
                    res[cnt[0]] = make_rec(K_ERROR, n_sl, n_sc, n_pos.len, 64'd0, 8'd0);
                    cnt = cnt + 2'd1;
                    redo = 1'b1;
                end else begin
                    n_pos = consume(n_pos, c);
                    if (!es[8]) begin
                        res[cnt[0]] = make_rec(K_ERROR, n_sl, n_sc, n_pos.len, 64'd0, 8'd0);
                        cnt = cnt + 2'd1;
                        n_mode = M_IDLE;
                    end else begin
                        res[cnt[0]] = make_rec(K_PAYLOAD, n_sl, n_sc, n_pos.len, 64'd0,
                                               es[7:0]);
                        cnt = cnt + 2'd1;
                        n_mode = M_STR_BODY;
                    end
                end
            end
            M_COMMENT: begin
                if ((c == CH_NL) || (c == CH_NUL)) begin
                    res[cnt[0]] = make_rec(K_COMMENT, n_sl, n_sc, n_pos.len, 64'd0, 8'd0);
                    cnt = cnt + 2'd1;
                    redo = 1'b1;
                end else begin
                    n_pos = consume(n_pos, c);
                end
            end
            default: begin
                redo = 1'b1;
            end
        endcase

        // the byte that ended a token (or any byte from idle) opens the next one
        if (redo) begin
            n_mode    = M_IDLE;
            n_sl      = n_pos.line;
            n_sc      = n_pos.col;
            n_pos.len = 16'd0;
            n_acc     = 64'd0;
            n_lit     = 8'd0;
            if (c == CH_NUL) begin
                res[cnt[0]] = make_rec(K_EOF, n_sl, n_sc, n_pos.len, 64'd0, 8'd0);
                cnt = cnt + 2'd1;
            end else if (is_ident_start(c)) begin
                n_mode = M_IDENT;
                n_pos  = consume(n_pos, c);
            end else if (is_digit(c)) begin
                n_acc  = {60'd0, c[3:0]};
                n_mode = (c == CH_ZERO) ? M_INT_ZERO : M_INT_DEC;
                n_pos  = consume(n_pos, c);
            end else begin
                n_pos = consume(n_pos, c);
                case (c)
                    CH_SPACE:  n_mode = M_SPACE;
                    CH_QUOTE:  n_mode = M_CHAR_OPEN;
                    CH_DQUOTE: n_mode = M_STR_BODY;
                    CH_BSLASH: n_mode = M_COMMENT;
                    CH_NL: begin
                        res[cnt[0]] = make_rec(K_EOL, n_sl, n_sc, n_pos.len, 64'd0, 8'd0);
                        cnt = cnt + 2'd1;
                    end
                    default: begin
                        res[cnt[0]] = make_rec(K_OTHER, n_sl, n_sc, n_pos.len, 64'd0, 8'd0);
                        cnt = cnt + 2'd1;
                    end
                endcase
            end
        end

        if (cnt == 2'd1) res[0].last = 1'b1;
        if (cnt == 2'd2) res[1].last = 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= M_IDLE;
            r_pos  <= '{line: 32'd1, col: 32'd1, len: 16'd0};
            r_sl   <= 32'd1;
            r_sc   <= 32'd1;
            r_acc  <= 64'd0;
            r_lit  <= 8'd0;
        end else if (i_accept) begin
            r_mode <= n_mode;
            r_pos  <= n_pos;
            r_sl   <= n_sl;
            r_sc   <= n_sc;
            r_acc  <= n_acc;
            r_lit  <= n_lit;
        end
    end

    assign o_res0  = res[0];
    assign o_res1  = res[1];
    assign o_count = cnt;

endmodule

// ----- hdl/source_text_tokenizer_unit.sv -----
// Top level: streaming source text tokenizer with a result queue.
//
// Takes one source byte per cycle (byte 0 = end of input) and reports tokens with
// their start line/column, length, integer value and literal byte. Each byte is
// scanned in the cycle it is accepted and yields zero, one or two result beats,
// which go into a DEPTH-entry queue; the output side drains one beat per cycle
// while i_stall is low. A byte is taken every cycle while the queue has room
// for two beats, so the sustained rate is one byte per cycle when results are
// taken as they appear and no byte yields two; results leave via the queue.
module source_text_tokenizer_unit #(
    parameter int DEPTH = stt_pkg::FIFO_DEPTH
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [7:0]  i_char_byte,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [3:0]  o_token_kind,
    output logic [31:0] o_start_line,
    output logic [31:0] o_start_column,
    output logic [15:0] o_lexeme_length,
    output logic [63:0] o_int_value,
    output logic [7:0]  o_byte_value,
    output logic        o_last_of_run
);
    import stt_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    t_result        res0, res1, head;
    logic [1:0]     scan_cnt;
    logic           in_acc, out_acc;
    logic [CW-1:0]  push_n;

    t_result        r_fifo [DEPTH];
    logic [AW-1:0]  r_wr, n_wr, r_rd, n_rd, wr1;
    logic [CW-1:0]  r_cnt, n_cnt;

    stt_scan u_scan (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (in_acc),
        .i_char_byte (i_char_byte),
        .o_res0      (res0),
        .o_res1      (res1),
        .o_count     (scan_cnt)
    );

    // keep room for the two beats one byte can cause
    assign o_stall = (r_cnt > CW'(DEPTH - 2));
    assign in_acc  = i_valid && !o_stall;
    assign o_valid = (r_cnt != '0);
    assign out_acc = o_valid && !i_stall;

    assign push_n = in_acc ? CW'(scan_cnt) : '0;
    assign wr1    = (r_wr == AW'(DEPTH - 1)) ? '0 : r_wr + AW'(1);

    always_comb begin
        n_wr = r_wr;
        if (push_n == CW'(1)) n_wr = wr1;
        else if (push_n == CW'(2)) n_wr = (wr1 == AW'(DEPTH - 1)) ? '0 : wr1 + AW'(1);
        n_rd = r_rd;
        if (out_acc) n_rd = (r_rd == AW'(DEPTH - 1)) ? '0 : r_rd + AW'(1);
        n_cnt = r_cnt + push_n - (out_acc ? CW'(1) : '0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push_n != '0) r_fifo[r_wr] <= res0;
        if (push_n == CW'(2)) r_fifo[wr1] <= res1;
    end

    assign head            = r_fifo[r_rd];
    assign o_token_kind    = head.kind;
    assign o_start_line    = head.start_line;
    assign o_start_column  = head.start_column;
    assign o_lexeme_length = head.length;
    assign o_int_value     = head.int_value;
    assign o_byte_value    = head.byte_value;
    assign o_last_of_run   = head.last;

endmodule

// ----- hdl/stt_checker.sv -----
// Port-level checks for the tokenizer, bound to the top level.
module stt_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_valid,
    input logic        i_stall,
    input logic [3:0]  o_token_kind,
    input logic [31:0] o_start_line,
    input logic [31:0] o_start_column,
    input logic [15:0] o_lexeme_length,
    input logic [63:0] o_int_value,
    input logic [7:0]  o_byte_value,
    input logic        o_last_of_run
);
    import stt_pkg::*;

    a_reset_empty: assert property (@(posedge i_clk) !i_rst_n |=> !o_valid)
        else $error("output valid right after reset");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_token_kind) && $stable(o_int_value)
            && $stable(o_byte_value) && $stable(o_start_line) && $stable(o_last_of_run)
            && $stable(o_start_column) && $stable(o_lexeme_length))
        else $error("stalled result beat changed");

    a_int_only: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_token_kind != K_INT) |-> (o_int_value == 64'd0))
        else $error("nonzero value on a non-integer token");

    a_byte_only: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_token_kind != K_CHAR) && (o_token_kind != K_PAYLOAD)
            |-> (o_byte_value == 8'd0))
        else $error("nonzero byte on a token that carries none");

    a_eof_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_token_kind == K_EOF) |-> o_last_of_run && (o_lexeme_length == 16'd0))
        else $error("end-of-file beat not last or not empty");

endmodule

bind source_text_tokenizer_unit stt_checker u_stt_checker (.*);
